// ----- rtl/core/osc_pkg.sv -----
package osc_pkg;

  // Fixed-point layout of the overlap volumes and the weights.
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_FRAC = 12;

  // Datapath widths.
  localparam int FIELD_W   = 32;
  localparam int WEIGHT_W  = 16;
  localparam int NUM_W     = 32;
  localparam int DEN_W     = 50;
  localparam int QUO_W     = 33;
  localparam int SHIFT_MAX = FRAC_BITS + WEIGHT_FRAC;
  localparam int N_W       = NUM_W + SHIFT_MAX;
  localparam int HI_W      = N_W - QUO_W;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCORE_MODE     = 2'd0;
  localparam logic [1:0] CFG_REF_WEIGHT     = 2'd1;
  localparam logic [1:0] CFG_ALIGNED_WEIGHT = 2'd2;

  typedef enum logic [1:0] {
    KIND_TOTAL,
    KIND_SHAPE,
    KIND_COLOR,
    KIND_COMBO
  } osc_kind_t;

  typedef enum logic [1:0] {
    FAM_TANIMOTO,
    FAM_TVERSKY,
    FAM_REFERENCE,
    FAM_ALIGNED
  } osc_fam_t;

  typedef struct packed {
    logic [FIELD_W-1:0] total_overlap;
    logic [FIELD_W-1:0] color_overlap;
    logic [FIELD_W-1:0] ref_self_overlap;
    logic [FIELD_W-1:0] aligned_self_overlap;
    logic [FIELD_W-1:0] ref_color_self_overlap;
    logic [FIELD_W-1:0] aligned_color_self_overlap;
  } osc_in_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic               saturated;
  } osc_out_t;

  // One quotient's operands after sign handling.
  typedef struct packed {
    logic             neg;
    logic             zero;
    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
  } osc_chan_t;

  // Request as it enters one divider lane.
  typedef struct packed {
    logic      vld;
    osc_kind_t kind;
    logic      long_shift;
    osc_chan_t chan;
  } osc_dreq_t;

  // One stage of the divider pipeline.
  typedef struct packed {
    logic             vld;
    osc_kind_t        kind;
    logic             neg;
    logic             zero;
    logic             ovf;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] nlow;
    logic [QUO_W-1:0] q;
  } osc_dstage_t;

  // Divider lane result.
  typedef struct packed {
    logic             vld;
    osc_kind_t        kind;
    logic             neg;
    logic             zero;
    logic             ovf;
    logic [QUO_W-1:0] q;
  } osc_quo_t;

endpackage

// ----- rtl/core/osc_prep.sv -----
module osc_prep (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  osc_pkg::osc_in_t                 in_data,
  input  logic [3:0]                       mode,
  input  logic [osc_pkg::WEIGHT_W-1:0]     alpha,
  input  logic [osc_pkg::WEIGHT_W-1:0]     beta,
  output osc_pkg::osc_dreq_t               req_a,
  output osc_pkg::osc_dreq_t               req_b
);
  import osc_pkg::*;

  // Stage 1: volumes of the chosen kind, as signed values.
  logic               s1_vld_r;
  osc_kind_t          s1_kind_r;
  osc_fam_t           s1_fam_r;
  logic signed [32:0] s1_oa_r, s1_ra_r, s1_aa_r, s1_ob_r, s1_rb_r, s1_ab_r;
  logic signed [32:0] t_s, c_s, rs_s, as_s, rc_s, ac_s;
  osc_kind_t          kind_in;

  assign kind_in = osc_kind_t'(mode[1:0]);
  assign t_s  = $signed({1'b0, in_data.total_overlap});
  assign c_s  = $signed({1'b0, in_data.color_overlap});
  assign rs_s = $signed({1'b0, in_data.ref_self_overlap});
  assign as_s = $signed({1'b0, in_data.aligned_self_overlap});
  assign rc_s = $signed({1'b0, in_data.ref_color_self_overlap});
  assign ac_s = $signed({1'b0, in_data.aligned_color_self_overlap});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r <= kind_in;
      s1_fam_r  <= osc_fam_t'(mode[3:2]);
      if (kind_in == KIND_TOTAL) begin
        s1_oa_r <= t_s;
        s1_ra_r <= rs_s;
        s1_aa_r <= as_s;
      end else begin
        s1_oa_r <= t_s - c_s;
        s1_ra_r <= rs_s - rc_s;
        s1_aa_r <= as_s - ac_s;
      end
      s1_ob_r <= c_s;
      s1_rb_r <= rc_s;
      s1_ab_r <= ac_s;
    end
  end

  // Stage 2: weighted self overlaps and the Tanimoto denominator.
  logic                     s2_vld_r;
  osc_kind_t                s2_kind_r;
  osc_fam_t                 s2_fam_r;
  logic signed [32:0]       s2_oa_r, s2_ob_r;
  logic signed [DEN_W-1:0]  s2_pra_r, s2_paa_r, s2_prb_r, s2_pab_r;
  logic signed [34:0]       s2_tana_r, s2_tanb_r;
  logic signed [16:0]       alpha_s, beta_s;

  assign alpha_s = $signed({1'b0, alpha});
  assign beta_s  = $signed({1'b0, beta});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind_r <= s1_kind_r;
      s2_fam_r  <= s1_fam_r;
      s2_oa_r   <= s1_oa_r;
      s2_ob_r   <= s1_ob_r;
      s2_pra_r  <= DEN_W'(s1_ra_r * alpha_s);
      s2_paa_r  <= DEN_W'(s1_aa_r * beta_s);
      s2_prb_r  <= DEN_W'(s1_rb_r * alpha_s);
      s2_pab_r  <= DEN_W'(s1_ab_r * beta_s);
      s2_tana_r <= 35'(s1_ra_r) + 35'(s1_aa_r) - 35'(s1_oa_r);
      s2_tanb_r <= 35'(s1_rb_r) + 35'(s1_ab_r) - 35'(s1_ob_r);
    end
  end

  // Stage 3: denominator of the family, magnitudes and signs.
  function automatic osc_chan_t chan_fn(osc_fam_t fam, logic signed [32:0] o,
                                        logic signed [DEN_W-1:0] pr,
                                        logic signed [DEN_W-1:0] pa,
                                        logic signed [34:0] tan);
    logic signed [DEN_W-1:0] den;
    logic signed [32:0]      o_abs;
    logic signed [DEN_W-1:0] den_abs;
    osc_chan_t               res;
    unique case (fam)
      FAM_TANIMOTO:  den = DEN_W'(tan);
      FAM_TVERSKY:   den = pr + pa;
      FAM_REFERENCE: den = pr;
      FAM_ALIGNED:   den = pa;
      default:       den = '0;
    endcase
    o_abs       = o[32] ? -o : o;
    den_abs     = den[DEN_W-1] ? -den : den;
    res.neg     = o[32] ^ den[DEN_W-1];
    res.zero    = (den == '0) || (o == '0);
    res.num_mag = o_abs[NUM_W-1:0];
    res.den_mag = den_abs;
    return res;
  endfunction

  osc_dreq_t s3_a_r, s3_b_r;

  // Only the valid bits are cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_a_r.vld <= 1'b0;
      s3_b_r.vld <= 1'b0;
    end else if (en) begin
      s3_a_r.vld        <= s2_vld_r;
      s3_b_r.vld        <= s2_vld_r;
      s3_a_r.kind       <= s2_kind_r;
      s3_b_r.kind       <= s2_kind_r;
      s3_a_r.long_shift <= (s2_fam_r != FAM_TANIMOTO);
      s3_b_r.long_shift <= (s2_fam_r != FAM_TANIMOTO);
      s3_a_r.chan       <= chan_fn(s2_fam_r, s2_oa_r, s2_pra_r, s2_paa_r, s2_tana_r);
      s3_b_r.chan       <= chan_fn(s2_fam_r, s2_ob_r, s2_prb_r, s2_pab_r, s2_tanb_r);
    end
  end

  assign req_a = s3_a_r;
  assign req_b = s3_b_r;

endmodule

// ----- rtl/core/osc_div.sv -----
module osc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  osc_pkg::osc_dreq_t  req,
  output osc_pkg::osc_quo_t   quo
);
  import osc_pkg::*;

  localparam int DEPTH = QUO_W + 1;

  osc_dstage_t st_r   [DEPTH];
  osc_dstage_t st_nxt [DEPTH];

  // Setup stage: scale the numerator and test for quotient overflow.
  logic [N_W-1:0] n_full;
  logic [N_W-1:0] n_long;

  assign n_long = {req.chan.num_mag, {SHIFT_MAX{1'b0}}};
  assign n_full = req.long_shift ? n_long : (n_long >> WEIGHT_FRAC);

  always_comb begin
    st_nxt[0].vld  = req.vld;
    st_nxt[0].kind = req.kind;
    st_nxt[0].neg  = req.chan.neg;
    st_nxt[0].zero = req.chan.zero;
    st_nxt[0].ovf  = DEN_W'(n_full[N_W-1:QUO_W]) >= req.chan.den_mag;
    st_nxt[0].rem  = DEN_W'(n_full[N_W-1:QUO_W]);
    st_nxt[0].den  = req.chan.den_mag;
    st_nxt[0].nlow = n_full[QUO_W-1:0];
    st_nxt[0].q    = '0;
  end

  // One restoring step per stage, one quotient bit each.
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;
    logic [DEN_W:0] diff;

    assign trial = {st_r[k].rem, st_r[k].nlow[QUO_W-1]};
    assign ge    = trial >= {1'b0, st_r[k].den};
    assign diff  = trial - {1'b0, st_r[k].den};

    always_comb begin
      st_nxt[k+1]      = st_r[k];
      st_nxt[k+1].rem  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      st_nxt[k+1].q    = {st_r[k].q[QUO_W-2:0], ge};
      st_nxt[k+1].nlow = {st_r[k].nlow[QUO_W-2:0], 1'b0};
    end
  end

  // Pipeline registers; only the valid bits are cleared by reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (!rst_n) begin
        st_r[i].vld <= 1'b0;
      end else if (en) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign quo.vld  = st_r[DEPTH-1].vld;
  assign quo.kind = st_r[DEPTH-1].kind;
  assign quo.neg  = st_r[DEPTH-1].neg;
  assign quo.zero = st_r[DEPTH-1].zero;
  assign quo.ovf  = st_r[DEPTH-1].ovf;
  assign quo.q    = st_r[DEPTH-1].q;

  // The remainder of a finished division stays below the divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    st_r[DEPTH-1].vld && !st_r[DEPTH-1].zero && !st_r[DEPTH-1].ovf
      |-> st_r[DEPTH-1].rem < st_r[DEPTH-1].den)
    else $error("divider remainder not below divisor");

endmodule

// ----- rtl/core/osc_post.sv -----
module osc_post (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  osc_pkg::osc_quo_t  quo_a,
  input  osc_pkg::osc_quo_t  quo_b,
  output logic               out_vld,
  output osc_pkg::osc_out_t  out_data
);
  import osc_pkg::*;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } osc_qv_t;

  // Apply the sign and clip one quotient to the result range.
  function automatic osc_qv_t clip_fn(osc_quo_t qi);
    osc_qv_t           res;
    logic signed [32:0] negv;
    negv = -$signed({1'b0, qi.q[31:0]});
    if (qi.zero) begin
      res.sat = 1'b0;
      res.val = '0;
    end else if (qi.neg) begin
      if (qi.ovf || qi.q[32] || (qi.q[31] && (|qi.q[30:0]))) begin
        res.sat = 1'b1;
        res.val = 32'sh8000_0000;
      end else begin
        res.sat = 1'b0;
        res.val = negv[31:0];
      end
    end else begin
      if (qi.ovf || qi.q[32] || qi.q[31]) begin
        res.sat = 1'b1;
        res.val = 32'sh7fff_ffff;
      end else begin
        res.sat = 1'b0;
        res.val = $signed(qi.q[31:0]);
      end
    end
    return res;
  endfunction

  osc_qv_t            qa, qb;
  logic signed [32:0] sum;
  osc_out_t           res_nxt;
  logic               out_vld_r;
  osc_out_t           out_r;

  assign qa  = clip_fn(quo_a);
  assign qb  = clip_fn(quo_b);
  assign sum = 33'(qa.val) + 33'(qb.val);

  // Pick the quotient of the kind, or add both for a combo score.
  always_comb begin
    unique case (quo_a.kind)
      KIND_TOTAL, KIND_SHAPE: begin
        res_nxt.score     = qa.val;
        res_nxt.saturated = qa.sat;
      end
      KIND_COLOR: begin
        res_nxt.score     = qb.val;
        res_nxt.saturated = qb.sat;
      end
      default: begin
        if (sum > 33'sh0_7fff_ffff) begin
          res_nxt.score     = 32'sh7fff_ffff;
          res_nxt.saturated = 1'b1;
        end else if (sum < -33'sh0_8000_0000) begin
          res_nxt.score     = 32'sh8000_0000;
          res_nxt.saturated = 1'b1;
        end else begin
          res_nxt.score     = sum[31:0];
          res_nxt.saturated = qa.sat | qb.sat;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= quo_a.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= res_nxt;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_r;

  // Both divider lanes carry the same request in lockstep.
  a_lane_vld: assert property (@(posedge clk) disable iff (!rst_n)
    quo_a.vld == quo_b.vld)
    else $error("divider lanes out of step");

  a_lane_kind: assert property (@(posedge clk) disable iff (!rst_n)
    quo_a.vld |-> quo_a.kind == quo_b.kind)
    else $error("divider lanes carry different kinds");

  // A held result does not change while the pipeline is frozen.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en && out_vld_r |=> $stable(out_r) && out_vld_r)
    else $error("result changed while frozen");

endmodule

// ----- rtl/core/overlap_similarity_scorer_core.sv -----
// Overlap similarity scorer.
// Input channel: in_valid / in_stall / in_data carries the six overlap volumes
// of one alignment, unsigned Q16.16. Result channel: out_valid / out_stall /
// out_data carries the signed Q16.16 score and a saturation flag. A request
// moves when its valid is high and its stall is low.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 score
// mode, 1 reference weight, 2 aligned weight); write only while the block
// holds no request in flight.
// The path from acceptance to out_valid runs through three operand stages
// (differences, weight multiply, denominator select), 34 stages of the two
// restoring divider lanes (one setup stage plus one quotient bit each), and
// the output register. A new request is taken every cycle unless the
// receiver stalls with a result waiting.
// When the receiver stalls with a result waiting, the whole pipeline freezes
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads score mode 3 (Tanimoto combo) and
// both weights to 1.0.
module overlap_similarity_scorer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  osc_pkg::osc_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output osc_pkg::osc_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [osc_pkg::WEIGHT_W-1:0]  cfg_wdata
);
  import osc_pkg::*;

  logic [3:0]          mode_r;
  logic [WEIGHT_W-1:0] alpha_r;
  logic [WEIGHT_W-1:0] beta_r;
  logic                adv;
  osc_dreq_t           req_a, req_b;
  osc_quo_t            quo_a, quo_b;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 4'd3;
      alpha_r <= WEIGHT_W'(4096);
      beta_r  <= WEIGHT_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCORE_MODE:     mode_r  <= cfg_wdata[3:0];
        CFG_REF_WEIGHT:     alpha_r <= cfg_wdata;
        CFG_ALIGNED_WEIGHT: beta_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished result is held by the receiver.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  osc_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (in_valid),
    .in_data (in_data),
    .mode    (mode_r),
    .alpha   (alpha_r),
    .beta    (beta_r),
    .req_a   (req_a),
    .req_b   (req_b)
  );

  osc_div u_div_a (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .req   (req_a),
    .quo   (quo_a)
  );

  osc_div u_div_b (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .req   (req_b),
    .quo   (quo_b)
  );

  osc_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .quo_a    (quo_a),
    .quo_b    (quo_b),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

endmodule
